[rtl/positional_array_list_unit_defines.svh]
// Assertion macros shared by the list unit. They sample on clk and are
// disabled while rst_n is low.
`ifndef POSITIONAL_ARRAY_LIST_UNIT_DEFINES_SVH
`define POSITIONAL_ARRAY_LIST_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define PAL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PAL_ASSERT_SAME(lbl, ante, cons, msg) \
  `PAL_ASSERT(lbl, (ante) |-> (cons), msg)
`define PAL_ASSERT_NEXT(lbl, ante, cons, msg) \
  `PAL_ASSERT(lbl, (ante) |=> (cons), msg)
`else
`define PAL_ASSERT(lbl, prop, msg)
`define PAL_ASSERT_SAME(lbl, ante, cons, msg)
`define PAL_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/pal_pkg.sv]
package pal_pkg;

  localparam int DATA_W  = 32;
  localparam int OP_W    = 2;
  localparam int POS_W   = 4;
  localparam int OCOUNT_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_WRITE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Per-cycle instruction for one cell of the chain.
  typedef struct packed {
    logic load;        // take the broadcast value
    logic take_left;   // take the lower neighbour's entry (insert shift)
    logic take_right;  // take the upper neighbour's entry (remove shift)
  } cell_ctl_t;

endpackage

[rtl/pal_cell.sv]
module pal_cell import pal_pkg::*; (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [DATA_W-1:0] left_i,
  input  logic [DATA_W-1:0] right_i,
  input  logic [DATA_W-1:0] value_i,
  output logic [DATA_W-1:0] data_o
);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;

  always_comb begin
    if (ctl.load) begin
      data_nxt = value_i;
    end else if (ctl.take_left) begin
      data_nxt = left_i;
    end else if (ctl.take_right) begin
      data_nxt = right_i;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule

[rtl/positional_array_list_unit.sv]
// Channel | Direction | Handshake            | Fields
// ------- | --------- | -------------------- | -------------------------------------------
// request | in        | in_valid, in_stall   | in_operation, in_position, in_value
// result  | out       | out_valid, out_stall | out_status, out_read_value, out_entry_count
//
// Each request is executed in the cycle it is accepted: every cell of the
// chain shifts, loads or holds at once, so one request completes per cycle.
// The result appears in the output register on the following cycle.
// While a result is held by out_stall, in_stall is raised and no request is
// taken. Reset clears the count; entries are not cleared.
`include "positional_array_list_unit_defines.svh"

module positional_array_list_unit import pal_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [OP_W-1:0]          in_operation,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               out_status,
  output logic signed [DATA_W-1:0] out_read_value,
  output logic [OCOUNT_W-1:0]      out_entry_count
);

  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int PW  = (CW > POS_W) ? CW : POS_W;
  localparam int RD  = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);
  localparam int RIW = (RD > 1) ? $clog2(RD) : 1;

  logic [CW-1:0]       count_r;
  logic [CW-1:0]       count_nxt;
  logic                out_valid_r;
  status_t             out_status_r;
  logic [DATA_W-1:0]   out_read_value_r;
  logic [OCOUNT_W-1:0] out_entry_count_r;

  logic              accept;
  op_t               op;
  logic [PW-1:0]     pos_ext;
  logic [PW-1:0]     cnt_ext;
  logic              in_range;
  logic              full;
  logic              empty;
  logic [CW-1:0]     pos_cw;
  logic [CW-1:0]     ins_pos;
  logic              do_ins;
  logic              do_rem;
  logic              do_wr;
  status_t           status;
  logic [DATA_W-1:0] rd_data;
  logic [DATA_W-1:0] rd_word;
  logic [RIW-1:0]    rd_idx;

  logic [DATA_W-1:0] cell_q [CAPACITY];
  logic [DATA_W-1:0] rd_bank [RD];

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign op       = op_t'(in_operation);

  assign pos_ext  = PW'(in_position);
  assign cnt_ext  = PW'(count_r);
  assign in_range = pos_ext < cnt_ext;
  assign full     = count_r == CW'(CAPACITY);
  assign empty    = count_r == '0;
  // Only meaningful when in_range holds, in which case the position fits.
  assign pos_cw   = CW'(pos_ext);
  // An insert at or beyond the end appends.
  assign ins_pos  = in_range ? pos_cw : count_r;

  assign rd_idx  = RIW'(pos_ext);
  assign rd_word = rd_bank[rd_idx];

  always_comb begin
    status  = ST_OK;
    do_ins  = 1'b0;
    do_rem  = 1'b0;
    do_wr   = 1'b0;
    rd_data = '0;
    case (op)
      OP_INSERT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          do_ins = accept;
        end
      end
      OP_REMOVE: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if (!in_range) begin
          status = ST_RANGE;
        end else begin
          do_rem = accept;
        end
      end
      OP_READ: begin
        if (!in_range) begin
          status = ST_RANGE;
        end else begin
          rd_data = rd_word;
        end
      end
      OP_WRITE: begin
        if (!in_range) begin
          status = ST_RANGE;
        end else begin
          do_wr = accept;
        end
      end
      default: begin
        status = ST_RANGE;
      end
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (do_ins) begin
      count_nxt = count_r + CW'(1);
    end else if (do_rem) begin
      count_nxt = count_r - CW'(1);
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      cell_ctl_t         ctl;
      logic [DATA_W-1:0] left_w;
      logic [DATA_W-1:0] right_w;

      assign ctl.load       = (do_ins && (CW'(gi) == ins_pos)) ||
                              (do_wr && (CW'(gi) == pos_cw));
      assign ctl.take_left  = do_ins && (CW'(gi) > ins_pos);
      assign ctl.take_right = do_rem && (CW'(gi) >= pos_cw);

      if (gi == 0) begin : g_first
        assign left_w = '0;
      end else begin : g_inner_left
        assign left_w = cell_q[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign right_w = '0;
      end else begin : g_inner_right
        assign right_w = cell_q[gi+1];
      end

      pal_cell u_cell (
        .clk     (clk),
        .ctl     (ctl),
        .left_i  (left_w),
        .right_i (right_w),
        .value_i (in_value),
        .data_o  (cell_q[gi])
      );
    end

    // Only the first cells can be addressed by a read position.
    for (gi = 0; gi < RD; gi++) begin : g_rd
      assign rd_bank[gi] = cell_q[gi];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r      <= status;
      out_read_value_r  <= rd_data;
      out_entry_count_r <= OCOUNT_W'(count_nxt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_value  = out_read_value_r;
  assign out_entry_count = out_entry_count_r;

  `PAL_ASSERT(a_count_bound, count_r <= CW'(CAPACITY), "count exceeds capacity")
  `PAL_ASSERT_NEXT(a_insert_grows, rst_n && do_ins, count_r == $past(count_r) + CW'(1),
                   "insert did not grow the list by one")
  `PAL_ASSERT_NEXT(a_refused_holds, rst_n && accept && status != ST_OK, $stable(count_r),
                   "refused request changed the count")
  `PAL_ASSERT_SAME(a_refused_zero, out_valid_r && out_status_r != ST_OK,
                   out_read_value_r == '0, "refused request returned a nonzero value")

endmodule
